// ===== sv/cda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants for the calendar date adder
// Control word layout, microcode store, status codes and month lengths.
// ----------------------------------------------------------------------------
package cda_pkg;

  // fixed field widths
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned SET_YEAR_W = 16;
  localparam int unsigned PC_W       = 4;

  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_CHK_SET,
    OP_DAY_STEP,
    OP_MON_INIT,
    OP_DIV_STEP,
    OP_MON_APPLY,
    OP_YR_APPLY,
    OP_COMMIT
  } op_e;

  // jump conditions; when false the step counter holds
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_N_ZERO,
    C_OUT_FREE,
    C_FUNC
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic       accept;
    logic       n_zero;
    logic       out_free;
    logic [1:0] func;
  } flags_t;

  // program addresses; set/days/months/years entries are consecutive for dispatch
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_DISP = 4'd1;
  localparam logic [PC_W-1:0] PC_SET  = 4'd2;
  localparam logic [PC_W-1:0] PC_DAYS = 4'd3;
  localparam logic [PC_W-1:0] PC_MONS = 4'd4;
  localparam logic [PC_W-1:0] PC_YRS  = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV  = 4'd6;
  localparam logic [PC_W-1:0] PC_MAPP = 4'd7;
  localparam logic [PC_W-1:0] PC_FIN  = 4'd8;

  // microcode store
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      PC_IDLE: w = '{op: OP_LATCH,     cond: C_ACCEPT,   tgt: PC_DISP};
      PC_DISP: w = '{op: OP_NOP,       cond: C_FUNC,     tgt: PC_SET};
      PC_SET:  w = '{op: OP_CHK_SET,   cond: C_ALWAYS,   tgt: PC_FIN};
      PC_DAYS: w = '{op: OP_DAY_STEP,  cond: C_N_ZERO,   tgt: PC_FIN};
      PC_MONS: w = '{op: OP_MON_INIT,  cond: C_ALWAYS,   tgt: PC_DIV};
      PC_YRS:  w = '{op: OP_YR_APPLY,  cond: C_ALWAYS,   tgt: PC_FIN};
      PC_DIV:  w = '{op: OP_DIV_STEP,  cond: C_ALWAYS,   tgt: PC_MAPP};
      PC_MAPP: w = '{op: OP_MON_APPLY, cond: C_ALWAYS,   tgt: PC_FIN};
      PC_FIN:  w = '{op: OP_COMMIT,    cond: C_OUT_FREE, tgt: PC_IDLE};
      default: w = '{op: OP_NOP,       cond: C_ALWAYS,   tgt: PC_IDLE};
    endcase
    return w;
  endfunction

  // days in month; leap year when the year is divisible by four
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cda_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_in_if: operation channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface cda_in_if #(
  parameter int unsigned AMOUNT_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [AMOUNT_BITS-1:0] amount;
  logic [15:0]            set_year;
  logic [3:0]             set_month;
  logic [4:0]             set_day;

  modport source (output valid, func, amount, set_year, set_month, set_day,
                  input ready);
  modport sink   (input valid, func, amount, set_year, set_month, set_day,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/cda_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_out_if: result channel
// Valid/ready channel carrying the date and status word.
// ----------------------------------------------------------------------------
interface cda_out_if #(
  parameter int unsigned YEAR_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [YEAR_BITS-1:0] year;
  logic [3:0]           month;
  logic [4:0]           day;
  logic [1:0]           status;

  modport source (output valid, year, month, day, status, input ready);
  modport sink   (input valid, year, month, day, status, output ready);
endinterface
`default_nettype wire

// ===== sv/cda_useq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_useq: microcode sequencer
// Step counter over the control store with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module cda_useq
  import cda_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire flags_t flags_i,
  output ucw_t        ctl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ucw_t            ucw;
  logic            take;

  // fetch and next-address select
  always_comb begin
    ucw = ucode_rom(pc_q);
    unique case (ucw.cond)
      C_ALWAYS:   take = 1'b1;
      C_ACCEPT:   take = flags_i.accept;
      C_N_ZERO:   take = flags_i.n_zero;
      C_OUT_FREE: take = flags_i.out_free;
      C_FUNC:     take = 1'b1;
      default:    take = 1'b1;
    endcase
    if (!take) begin
      pc_d = pc_q;
    end else if (ucw.cond == C_FUNC) begin
      pc_d = ucw.tgt + PC_W'(flags_i.func);
    end else begin
      pc_d = ucw.tgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o = ucw;

  // program never runs past its last step
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_FIN)
    else $error("sequencer left program");

endmodule
`default_nettype wire

// ===== sv/calendar_date_adder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_adder_core: calendar date register with add operations
// Holds one date and applies set / add days / add months / add years.
// ----------------------------------------------------------------------------
// One operation word is taken at a time and gives one result word. After the
// accept step a set or an add of years runs the dispatch step, its own step and
// the commit step; an add of months runs an init, a divide and an apply step (the
// month total is split into years and a month in one step by a reciprocal
// multiply), and an add of n days walks n days, fewer when the walk runs off the top year, since the day
// loop walks the calendar one day per cycle. A result register holds the finished word;
// the next word is taken once the sequencer returns to its idle step, and a
// stalled result holds the sequencer at its commit step. Leap years are those
// divisible by four. A rejected load or an add that would carry the year past
// 2^YEAR_BITS-1 leaves the date unchanged and reports it with a non-zero
// status.
module calendar_date_adder_core
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_BITS   = 16,
  parameter int unsigned AMOUNT_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cda_in_if.sink    in_i,
  cda_out_if.source out_o
);

  localparam int unsigned DIVW  = AMOUNT_BITS + 1;
  localparam int unsigned Q3W   = DIVW - 2;
  localparam int unsigned Q3MW  = Q3W + 1;
  localparam int unsigned Q12W  = Q3W - 1;
  localparam int unsigned PRODW = 2 * Q3W + 1;
  localparam int unsigned SUMW = ((YEAR_BITS > DIVW) ? YEAR_BITS : DIVW) + 1;
  localparam int unsigned CMPW = (YEAR_BITS > SET_YEAR_W) ? YEAR_BITS : SET_YEAR_W;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
  // ceil(2^(Q3W+2) / 3): exact divide by three for Q3W-bit values
  localparam longint unsigned DIV3_FULL = ((64'd1 << (Q3W + 2)) / 64'd3) + 64'd1;
  localparam logic [Q3MW-1:0] DIV3_MUL  = Q3MW'(DIV3_FULL);

  // control
  ucw_t   ctl;
  flags_t flags;
  logic   accept, out_free;

  // stored date and working copy
  logic [YEAR_BITS-1:0]   cur_y_q, cur_y_d, w_y_q, w_y_d;
  logic [MONTH_W-1:0]     cur_m_q, cur_m_d, w_m_q, w_m_d;
  logic [DAY_W-1:0]       cur_d_q, cur_d_d, w_d_q, w_d_d;
  logic [AMOUNT_BITS-1:0] n_q, n_d;
  status_e                st_q, st_d;
  logic [1:0]             func_q, func_d;
  logic [SET_YEAR_W-1:0]  sy_q, sy_d;
  logic [MONTH_W-1:0]     sm_q, sm_d;
  logic [DAY_W-1:0]       sd_q, sd_d;

  // divide-by-twelve unit
  logic [DIVW-1:0]    quo_q, quo_d;
  logic [MONTH_W-1:0] rem_q, rem_d;
  logic [Q3W-1:0]     quarter;
  logic [Q12W-1:0]    q12;
  logic [1:0]         r3;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [YEAR_BITS-1:0] out_y_q, out_y_d;
  logic [MONTH_W-1:0]   out_m_q, out_m_d;
  logic [DAY_W-1:0]     out_d_q, out_d_d;
  status_e              out_st_q, out_st_d;

  // shared year adder and length lookups
  logic [SUMW-1:0]    sum;
  logic [MONTH_W-1:0] apply_m;
  logic [DAY_W-1:0]   apply_len, step_len, set_len, cur_len;
  logic [CMPW-1:0]    sy_ext;
  logic               set_ok;

  cda_useq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctl_o  (ctl)
  );

  assign in_i.ready = (ctl.op == OP_LATCH);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign flags.accept   = accept;
  assign flags.n_zero   = (n_q == '0);
  assign flags.out_free = out_free;
  assign flags.func     = func_q;

  // shared adder: quotient for months, amount for years
  assign sum = SUMW'(w_y_q) + ((ctl.op == OP_MON_APPLY) ? SUMW'(quo_q) : SUMW'(n_q));
  assign apply_m   = (ctl.op == OP_MON_APPLY) ? (rem_q + 4'd1) : w_m_q;
  assign apply_len = month_len(sum[1:0] == 2'b00, apply_m);
  assign step_len  = month_len(w_y_q[1:0] == 2'b00, w_m_q);
  assign set_len   = month_len(sy_q[1:0] == 2'b00, sm_q);
  assign cur_len   = month_len(cur_y_q[1:0] == 2'b00, cur_m_q);

  // divide by twelve: quarter the total, then divide by three by reciprocal;
  // the remainder by three is below three, so its low two bits are enough
  assign quarter = quo_q[DIVW-1:2];
  assign q12     = Q12W'((PRODW'(quarter) * PRODW'(DIV3_MUL)) >> (Q3W + 2));
  assign r3      = quarter[1:0] - (q12[1:0] + {q12[0], 1'b0});

  // load check
  assign sy_ext = CMPW'(sy_q);
  assign set_ok = (sy_ext != '0) && (sy_ext <= CMPW'(YEAR_MAX)) &&
                  (sm_q != '0) && (sm_q <= MONTHS_PER_YEAR) &&
                  (sd_q != '0) && (sd_q <= set_len);

  // datapath
  always_comb begin
    cur_y_d = cur_y_q;  cur_m_d = cur_m_q;  cur_d_d = cur_d_q;
    w_y_d   = w_y_q;    w_m_d   = w_m_q;    w_d_d   = w_d_q;
    n_d     = n_q;      st_d    = st_q;     func_d  = func_q;
    sy_d    = sy_q;     sm_d    = sm_q;     sd_d    = sd_q;
    quo_d   = quo_q;    rem_d   = rem_q;
    out_y_d = out_y_q;  out_m_d = out_m_q;  out_d_d = out_d_q;
    out_st_d = out_st_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (ctl.op)
      OP_LATCH: begin
        if (accept) begin
          w_y_d  = cur_y_q;
          w_m_d  = cur_m_q;
          w_d_d  = cur_d_q;
          n_d    = in_i.amount;
          st_d   = ST_OK;
          func_d = in_i.func;
          sy_d   = in_i.set_year;
          sm_d   = in_i.set_month;
          sd_d   = in_i.set_day;
        end
      end
      OP_CHK_SET: begin
        if (set_ok) begin
          w_y_d = YEAR_BITS'(sy_ext);
          w_m_d = sm_q;
          w_d_d = sd_q;
        end else begin
          st_d = ST_INVALID;
        end
      end
      // one calendar day per cycle
      OP_DAY_STEP: begin
        if (n_q != '0) begin
          n_d = n_q - 1'b1;
          if (w_d_q < step_len) begin
            w_d_d = w_d_q + 1'b1;
          end else if (w_m_q < MONTHS_PER_YEAR) begin
            w_d_d = 5'd1;
            w_m_d = w_m_q + 1'b1;
          end else if (w_y_q == YEAR_MAX) begin
            st_d = ST_OVERFLOW;
            n_d  = '0;
          end else begin
            w_d_d = 5'd1;
            w_m_d = 4'd1;
            w_y_d = w_y_q + 1'b1;
          end
        end
      end
      OP_MON_INIT: begin
        quo_d = DIVW'(w_m_q) + DIVW'(n_q) - DIVW'(1);
        rem_d = '0;
      end
      // month total into years carried and a zero-based month
      OP_DIV_STEP: begin
        quo_d = DIVW'(q12);
        rem_d = {r3, quo_q[1:0]};
      end
      OP_MON_APPLY, OP_YR_APPLY: begin
        if (|sum[SUMW-1:YEAR_BITS]) begin
          st_d = ST_OVERFLOW;
        end else begin
          w_y_d = sum[YEAR_BITS-1:0];
          w_m_d = apply_m;
          if (w_d_q > apply_len) begin
            w_d_d = apply_len;
          end
        end
      end
      OP_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          if (st_q == ST_OK) begin
            cur_y_d = w_y_q;  cur_m_d = w_m_q;  cur_d_d = w_d_q;
            out_y_d = w_y_q;  out_m_d = w_m_q;  out_d_d = w_d_q;
          end else begin
            out_y_d = cur_y_q;  out_m_d = cur_m_q;  out_d_d = cur_d_q;
          end
        end
      end
      default: ;
    endcase
  end

  // control and stored date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_y_q     <= YEAR_BITS'(1);
      cur_m_q     <= 4'd1;
      cur_d_q     <= 5'd1;
      out_valid_q <= 1'b0;
      st_q        <= ST_OK;
      rem_q       <= '0;
      n_q         <= '0;
    end else begin
      cur_y_q     <= cur_y_d;
      cur_m_q     <= cur_m_d;
      cur_d_q     <= cur_d_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      rem_q       <= rem_d;
      n_q         <= n_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    w_y_q    <= w_y_d;
    w_m_q    <= w_m_d;
    w_d_q    <= w_d_d;
    func_q   <= func_d;
    sy_q     <= sy_d;
    sm_q     <= sm_d;
    sd_q     <= sd_d;
    quo_q    <= quo_d;
    out_y_q  <= out_y_d;
    out_m_q  <= out_m_d;
    out_d_q  <= out_d_d;
    out_st_q <= out_st_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.year   = out_y_q;
  assign out_o.month  = out_m_q;
  assign out_o.day    = out_d_q;
  assign out_o.status = out_st_q;

  // stored date is always a real calendar date
  a_cur_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_m_q >= 4'd1) && (cur_m_q <= MONTHS_PER_YEAR) &&
    (cur_d_q >= 5'd1) && (cur_d_q <= cur_len))
    else $error("stored date out of calendar");

  // taking a word moves the sequencer off its idle step
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("ready stayed high after accept");

  // a rejected operation leaves the stored date alone
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == OP_COMMIT) && out_free && (st_q != ST_OK) |=>
      $stable(cur_y_q) && $stable(cur_m_q) && $stable(cur_d_q))
    else $error("rejected operation changed date");

  // division remainder stays below twelve
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < MONTHS_PER_YEAR)
    else $error("month remainder out of range");

  // a result appears only from the commit step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.op == OP_COMMIT))
    else $error("result word without commit");

endmodule
`default_nettype wire
